// File: rtl/nrp_pkg.sv
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and constants for the nonrepeating random picker.
// ----------------------------------------------------------------------------
package nrp_pkg;

  localparam int SIZE_W        = 7;
  localparam int RAND_W        = 31;
  localparam int PICK_W        = 6;
  localparam int DEF_MAX_SLOTS = 64;
  localparam int SLOT_CAP      = 127;
  localparam int DIV_STEPS     = RAND_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } nrp_state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic scan_step;
    logic commit;
  } nrp_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic div_last;
    logic scan_hit;
    logic out_free;
  } nrp_sts_t;

endpackage

// File: rtl/nrp_ctrl.sv
// ----------------------------------------------------------------------------
// nrp_ctrl
// Sequencer for one draw: accept, history check, division, rank scan, result.
// ----------------------------------------------------------------------------
module nrp_ctrl import nrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  nrp_sts_t sts,
  output nrp_cmd_t cmd
);

  nrp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.size_zero ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_PREP: cmd.prep      = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DONE: cmd.commit    = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/nrp_datapath.sv
// ----------------------------------------------------------------------------
// nrp_datapath
// Draw history, bit-serial modulo, rank scan over the used mask, result reg.
// ----------------------------------------------------------------------------
module nrp_datapath import nrp_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_pool_size,
  input  logic [RAND_W-1:0] in_random_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PICK_W-1:0] out_picked_index,
  input  nrp_cmd_t          cmd,
  output nrp_sts_t          sts
);

  // pool_size never exceeds SLOT_CAP, so higher slots are never reached
  localparam int SLOTS = (MAX_SLOTS < SLOT_CAP) ? MAX_SLOTS : SLOT_CAP;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SIZE_W-1:0]    pool_size_r;
  logic [SLOTS-1:0]     used_mask_r;
  logic [SIZE_W-1:0]    draw_count_r;
  logic [SIZE_W-1:0]    remembered_r;
  logic [SIZE_W-1:0]    size_r;
  logic                 zero_r;
  logic [RAND_W-1:0]    rnd_r;
  logic [SIZE_W-1:0]    unused_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [SIZE_W-1:0]    rank_r;
  logic [IDX_W-1:0]     scan_idx_r;
  logic                 out_valid_r;
  logic [PICK_W-1:0]    out_pick_r;

  logic [SIZE_W-1:0]    size_eff;
  logic                 hist_clear;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      trial_sub;
  logic [SIZE_W-1:0]    rem_nxt;
  logic                 slot_used;

  assign size_eff   = (pool_size_r > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : pool_size_r;
  assign hist_clear = (remembered_r != size_r) || (draw_count_r >= size_r);
  assign trial      = {rem_r, rnd_r[RAND_W-1]};
  assign trial_sub  = trial - {1'b0, unused_r};
  assign rem_nxt    = trial_sub[SIZE_W] ? trial[SIZE_W-1:0] : trial_sub[SIZE_W-1:0];
  assign slot_used  = used_mask_r[scan_idx_r];

  assign sts.size_zero = (pool_size_r == '0);
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.scan_hit  = !slot_used && (rank_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r  <= '0;
      used_mask_r  <= '0;
      draw_count_r <= '0;
      remembered_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_size_r <= cfg_pool_size;
      end
      if (cmd.prep && hist_clear) begin
        used_mask_r  <= '0;
        draw_count_r <= '0;
        remembered_r <= size_r;
      end
      if (cmd.commit && !zero_r) begin
        used_mask_r[scan_idx_r] <= 1'b1;
        draw_count_r            <= draw_count_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r <= size_eff;
      zero_r <= sts.size_zero;
      rnd_r  <= in_random_value;
    end
    if (cmd.prep) begin
      unused_r  <= size_r - (hist_clear ? '0 : draw_count_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      rnd_r     <= {rnd_r[RAND_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
      if (sts.div_last) begin
        rank_r     <= rem_nxt;
        scan_idx_r <= '0;
      end
    end
    if (cmd.scan_step && !sts.scan_hit) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (!slot_used) begin
        rank_r <= rank_r - 1'b1;
      end
    end
    if (cmd.commit) begin
      out_pick_r <= zero_r ? '0 : PICK_W'(scan_idx_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_index = out_pick_r;

endmodule

// File: rtl/nonrepeating_random_picker_unit.sv
// ----------------------------------------------------------------------------
// nonrepeating_random_picker_unit
// Draws pool indices without replacement from a supplied random value.
// ----------------------------------------------------------------------------
// One draw runs from input transfer to result load through a 31-step
// bit-serial modulo by the unused count and a one-bit-per-cycle rank scan of
// the used mask up to the picked index (at most min(MAX_SLOTS, SLOT_CAP) - 1).
// A pool size of zero returns 0 without the division or the scan. One draw is
// in flight at a time; the result sits in an output register so the next
// input transfer can be taken while it waits.
module nonrepeating_random_picker_unit import nrp_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_pool_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAND_W-1:0] in_random_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PICK_W-1:0] out_picked_index
);

  nrp_cmd_t cmd;
  nrp_sts_t sts;

  nrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrp_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_pool_size    (cfg_pool_size),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_picked_index (out_picked_index),
    .cmd              (cmd),
    .sts              (sts)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.prep, cmd.div_step, cmd.scan_step, cmd.commit}))
    else $error("more than one datapath command");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

endmodule

// File: tb/nrp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nrp_checker
// Watches the config port and both channels of the picker. It keeps its own
// used-index mask, draw count and remembered size, works out the index that
// each accepted draw must return, and compares every result transfer with the
// oldest pending pick.
// ----------------------------------------------------------------------------
module nrp_checker import nrp_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_pool_size,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [RAND_W-1:0] in_random_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [PICK_W-1:0] out_picked_index,
  output int                fail_count,
  output int                outstanding
);

  logic [SIZE_W-1:0]    pool_reg;
  logic [MAX_SLOTS-1:0] taken;
  int unsigned          drawn;
  int unsigned          last_size;
  logic [PICK_W-1:0]    picks_due[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Draw without replacement; updates the mask, count and remembered size.
  function automatic logic [PICK_W-1:0] draw_index(input logic [RAND_W-1:0] rnd);
    int unsigned eff;
    int unsigned free_cnt;
    int unsigned rank;
    int unsigned pick;
    bit          found;
    eff = (pool_reg > MAX_SLOTS) ? MAX_SLOTS : pool_reg;
    if (eff == 0)
      return '0;
    if (last_size != eff || drawn >= eff) begin
      taken     = '0;
      drawn     = 0;
      last_size = eff;
    end
    free_cnt = 0;
    for (int i = 0; i < eff; i++)
      if (!taken[i])
        free_cnt++;
    if (free_cnt == 0) begin
      taken     = '0;
      drawn     = 0;
      last_size = eff;
      free_cnt  = eff;
    end
    rank  = rnd % free_cnt;
    pick  = 0;
    found = 1'b0;
    for (int i = 0; i < eff; i++) begin
      if (!found && !taken[i]) begin
        if (rank == 0) begin
          pick  = i;
          found = 1'b1;
        end else begin
          rank--;
        end
      end
    end
    taken[pick] = 1'b1;
    drawn       = drawn + 1;
    return pick[PICK_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [PICK_W-1:0] want;
    if (!rst_n) begin
      pool_reg  = '0;
      taken     = '0;
      drawn     = 0;
      last_size = 0;
      picks_due.delete();
    end else begin
      if (cfg_we)
        pool_reg = cfg_pool_size;
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          $display("%0t: unexpected picked_index transfer: expected none, actual %0d",
                   $time, out_picked_index);
          fail_count <= fail_count + 1;
        end else begin
          want = picks_due.pop_front();
          if (out_picked_index !== want) begin
            $display("%0t: picked_index mismatch: expected %0d, actual %0d",
                     $time, want, out_picked_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        picks_due.push_back(draw_index(in_random_value));
    end
    outstanding <= picks_due.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the nonrepeating random picker. Runs a short directed set of
// draws over empty, single, small, full and oversized pools, then random
// phases of draws at random pool sizes, with random gaps and output stalls in
// all phases but one. Results are checked by nrp_checker.
// ----------------------------------------------------------------------------
module tb;
  import nrp_pkg::*;

  localparam int RANDOM_DRAWS = 530;
  localparam int STALL_PCT    = 17;
  localparam int WATCH_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  logic [SIZE_W-1:0] cfg_pool_size   = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [RAND_W-1:0] in_random_value = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [PICK_W-1:0] out_picked_index;

  logic idle_on = 1'b1;
  int   fail_count;
  int   outstanding;
  int   quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nonrepeating_random_picker_unit #(.MAX_SLOTS(DEF_MAX_SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_pool_size    (cfg_pool_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_picked_index (out_picked_index)
  );

  nrp_checker #(.MAX_SLOTS(DEF_MAX_SLOTS)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_pool_size    (cfg_pool_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_picked_index (out_picked_index),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always @(posedge clk)
    out_stall <= idle_on && ($urandom_range(99) < STALL_PCT);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_draw(input logic [RAND_W-1:0] rnd);
    while (idle_on && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_random_value <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_pool(input logic [SIZE_W-1:0] sz);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_pool_size <= sz;
    cfg_we        <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RAND_W-1:0] pick_rand();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60)
      return RAND_W'($urandom);
    else if (r < 75)
      return RAND_W'($urandom_range(0, 200));
    else if (r < 85)
      return {RAND_W{1'b1}};
    else
      return RAND_W'($urandom_range(0, 127));
  endfunction

  initial begin
    logic [SIZE_W-1:0] sz;
    int                n;
    int                sent;
    int                phase;
    int unsigned       r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pool straight out of reset
    send_draw('0);
    send_draw({RAND_W{1'b1}});
    set_pool(SIZE_W'(1));
    send_draw({RAND_W{1'b1}});
    send_draw('0);
    send_draw(RAND_W'($urandom));
    // small pool, exhausted and refilled
    set_pool(SIZE_W'(3));
    send_draw({RAND_W{1'b1}});
    send_draw('0);
    send_draw(RAND_W'(1));
    send_draw(RAND_W'(5));
    // oversized pools saturate to the full slot count
    set_pool({SIZE_W{1'b1}});
    send_draw({RAND_W{1'b1}});
    send_draw('0);
    send_draw(RAND_W'(63));
    set_pool(SIZE_W'(DEF_MAX_SLOTS));
    send_draw(RAND_W'(64));
    send_draw(RAND_W'($urandom));
    send_draw(RAND_W'(1));
    set_pool(SIZE_W'(DEF_MAX_SLOTS + 1));
    send_draw({RAND_W{1'b1}});
    send_draw('0);
    // an empty pool leaves the history alone
    set_pool('0);
    send_draw(RAND_W'($urandom));
    set_pool(SIZE_W'(DEF_MAX_SLOTS));
    send_draw(RAND_W'($urandom));
    send_draw('0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_DRAWS) begin
      r = $urandom_range(99);
      if (r < 8)
        sz = '0;
      else if (r < 45)
        sz = SIZE_W'($urandom_range(1, 8));
      else if (r < 70)
        sz = SIZE_W'($urandom_range(9, DEF_MAX_SLOTS - 1));
      else if (r < 85)
        sz = SIZE_W'(DEF_MAX_SLOTS);
      else
        sz = SIZE_W'($urandom_range(DEF_MAX_SLOTS + 1, SLOT_CAP));
      set_pool(sz);
      idle_on <= (phase != 3);
      n = (phase == 3) ? 70 : $urandom_range(5, 80);
      for (int k = 0; k < n; k++) begin
        if (phase == 5 && k == n / 2)
          wait_drained();
        send_draw(pick_rand());
      end
      sent  = sent + n;
      phase = phase + 1;
    end

    idle_on <= 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
